@@ rtl/cst_pkg.sv @@
// shared types and constants for the three-key column sorter
`timescale 1ns / 1ps
package cst_pkg;

	// port width of every row field and number of row ports
	localparam int unsigned PORT_W = 16;
	localparam int unsigned PORT_ROWS = 8;

	typedef logic signed [PORT_W-1:0] port_elem_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic load;   // a new column is inserted this cycle
		logic shift;  // every cell takes its right neighbour's column
	} cell_ctl_t;

endpackage

@@ rtl/cst_cell.sv @@
// one sorting cell: holds a column, compares it with the incoming one, hands data on
`timescale 1ns / 1ps
module cst_cell #(
	parameter int unsigned ROWS = 8,
	parameter int unsigned ELEM_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cst_pkg::cell_ctl_t           ctl,
	input  logic [ROWS*ELEM_WIDTH-1:0]   new_col,
	input  logic                         prev_ins,
	input  logic [ROWS*ELEM_WIDTH-1:0]   prev_col,
	input  logic                         prev_vld,
	input  logic [ROWS*ELEM_WIDTH-1:0]   next_col,
	input  logic                         next_vld,
	output logic                         ins,
	output logic [ROWS*ELEM_WIDTH-1:0]   col,
	output logic                         vld
);
	import cst_pkg::*;

	logic [ROWS*ELEM_WIDTH-1:0] col_q;
	logic                       vld_q;
	logic signed [ELEM_WIDTH-1:0] s0, s1, s2, n0, n1, n2;
	logic                       after;

	// key rows of the held and the incoming column
	assign s0 = col_q[0*ELEM_WIDTH +: ELEM_WIDTH];
	assign s1 = col_q[1*ELEM_WIDTH +: ELEM_WIDTH];
	assign s2 = col_q[2*ELEM_WIDTH +: ELEM_WIDTH];
	assign n0 = new_col[0*ELEM_WIDTH +: ELEM_WIDTH];
	assign n1 = new_col[1*ELEM_WIDTH +: ELEM_WIDTH];
	assign n2 = new_col[2*ELEM_WIDTH +: ELEM_WIDTH];

	// held column must move behind the new one: row 0 up, row 1 down, row 2 up
	always_comb begin
		if (s0 != n0) begin
			after = s0 > n0;
		end else if (s1 != n1) begin
			after = s1 < n1;
		end else begin
			after = s2 > n2;
		end
	end

	// ties keep the held column in front, so arrival order survives
	assign ins = !vld_q || after;

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (prev_ins) begin
				col_q <= prev_col;
			end else if (ins) begin
				col_q <= new_col;
			end
		end else if (ctl.shift) begin
			col_q <= next_col;
		end
	end

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.load) begin
			if (prev_ins) begin
				vld_q <= prev_vld;
			end else if (ins) begin
				vld_q <= 1'b1;
			end
		end else if (ctl.shift) begin
			vld_q <= next_vld;
		end
	end

	assign col = col_q;
	assign vld = vld_q;

endmodule

@@ rtl/column_sort_three_key.sv @@
// top level of the three-key column sorter: cell chain, load and drain control
`timescale 1ns / 1ps
// Stable multi-key column sorter. Columns are loaded one per cycle; each
// transfer is inserted into a chain of COLS sorting cells in the same cycle, so
// loading sustains one column per clock. The column flagged in_last (or the
// COLS-th column) closes the matrix: from the next cycle the sorted columns
// leave from the head of the chain, one per clock while out_ready is high,
// the last one flagged out_last; in_ready is low during output. Order is
// row 0 ascending, row 1 descending, row 2 ascending, ties in arrival order.
// Rows at ROWS and above are ignored on input and read as zero on output.
module column_sort_three_key #(
	parameter int unsigned COLS = 16,
	parameter int unsigned ROWS = 8,
	parameter int unsigned ELEM_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cst_pkg::port_elem_t  in_row0,
	input  cst_pkg::port_elem_t  in_row1,
	input  cst_pkg::port_elem_t  in_row2,
	input  cst_pkg::port_elem_t  in_row3,
	input  cst_pkg::port_elem_t  in_row4,
	input  cst_pkg::port_elem_t  in_row5,
	input  cst_pkg::port_elem_t  in_row6,
	input  cst_pkg::port_elem_t  in_row7,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cst_pkg::port_elem_t  out_row0,
	output cst_pkg::port_elem_t  out_row1,
	output cst_pkg::port_elem_t  out_row2,
	output cst_pkg::port_elem_t  out_row3,
	output cst_pkg::port_elem_t  out_row4,
	output cst_pkg::port_elem_t  out_row5,
	output cst_pkg::port_elem_t  out_row6,
	output cst_pkg::port_elem_t  out_row7,
	output logic                 out_last
);
	import cst_pkg::*;

	localparam int unsigned CNT_W = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int unsigned COL_W = ROWS * ELEM_WIDTH;

	port_elem_t               in_rows [PORT_ROWS];
	port_elem_t               out_rows [PORT_ROWS];
	logic [COL_W-1:0]         new_col;
	logic [COL_W-1:0]         cell_col [COLS];
	logic                     cell_vld [COLS];
	logic                     cell_ins [COLS];
	cell_ctl_t                ctl;
	logic                     in_xfer, out_xfer, close;
	logic [CNT_W-1:0]         count_q;
	logic                     drain_q;

	assign in_rows[0] = in_row0;
	assign in_rows[1] = in_row1;
	assign in_rows[2] = in_row2;
	assign in_rows[3] = in_row3;
	assign in_rows[4] = in_row4;
	assign in_rows[5] = in_row5;
	assign in_rows[6] = in_row6;
	assign in_rows[7] = in_row7;

	// wrap each stored row to the element width by sign extension or truncation
	for (genvar r = 0; r < ROWS; r++) begin : g_in
		assign new_col[r*ELEM_WIDTH +: ELEM_WIDTH] = ELEM_WIDTH'(in_rows[r]);
	end

	// handshake and chain commands
	assign in_ready  = !drain_q;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = drain_q;
	assign out_xfer  = out_valid && out_ready;
	assign close     = in_last || (count_q == CNT_W'(COLS - 1));
	assign ctl       = '{load: in_xfer, shift: out_xfer};

	// the chain of cells
	for (genvar c = 0; c < COLS; c++) begin : g_cell
		logic             p_ins, p_vld, n_vld;
		logic [COL_W-1:0] p_col, n_col;
		if (c == 0) begin : g_head
			assign p_ins = 1'b0;
			assign p_vld = 1'b0;
			assign p_col = new_col;
		end else begin : g_mid
			assign p_ins = cell_ins[c-1];
			assign p_vld = cell_vld[c-1];
			assign p_col = cell_col[c-1];
		end
		if (c == COLS - 1) begin : g_tail
			assign n_vld = 1'b0;
			assign n_col = cell_col[c];
		end else begin : g_body
			assign n_vld = cell_vld[c+1];
			assign n_col = cell_col[c+1];
		end
		cst_cell #(
			.ROWS       (ROWS),
			.ELEM_WIDTH (ELEM_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.new_col  (new_col),
			.prev_ins (p_ins),
			.prev_col (p_col),
			.prev_vld (p_vld),
			.next_col (n_col),
			.next_vld (n_vld),
			.ins      (cell_ins[c]),
			.col      (cell_col[c]),
			.vld      (cell_vld[c])
		);
	end

	// column count and output phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drain_q <= 1'b0;
		end else if (in_xfer) begin
			if (close) begin
				count_q <= '0;
				drain_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end else if (out_xfer && !cell_vld[1]) begin
			drain_q <= 1'b0;
		end
	end

	// head of the chain drives the result
	for (genvar r = 0; r < PORT_ROWS; r++) begin : g_out
		if (r < ROWS) begin : g_used
			logic signed [ELEM_WIDTH-1:0] e;
			assign e = cell_col[0][r*ELEM_WIDTH +: ELEM_WIDTH];
			assign out_rows[r] = PORT_W'(e);
		end else begin : g_zero
			assign out_rows[r] = '0;
		end
	end

	assign out_row0 = out_rows[0];
	assign out_row1 = out_rows[1];
	assign out_row2 = out_rows[2];
	assign out_row3 = out_rows[3];
	assign out_row4 = out_rows[4];
	assign out_row5 = out_rows[5];
	assign out_row6 = out_rows[6];
	assign out_row7 = out_rows[7];
	assign out_last = !cell_vld[1];

`ifndef ASSERT_OFF
	// a result is shown only while the head cell holds a column
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_vld[0])
		else $error("result shown from an empty head cell");

	// occupied cells stay packed at the head of the chain (checked on the first two cells)
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		cell_vld[1] |-> cell_vld[0])
		else $error("gap in the cell chain");

	// no columns are being counted during the output phase
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (count_q == '0))
		else $error("column count not cleared for output phase");

	// the final result ends the output phase
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_last) |=> (in_ready && !cell_vld[0]))
		else $error("output phase did not end after final transfer");
`endif

endmodule

@@ verif/tb_column_sort_three_key.sv @@
// testbench for the three-key column sorter: stable compound-key order checked per transfer
`timescale 1ns / 1ps
module tb_column_sort_three_key;
	import cst_pkg::*;

	localparam int unsigned COLS = 16;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 2 * COLS + 8;
	localparam int unsigned PHASE_ITEMS = 44;

	typedef struct {
		port_elem_t rows [PORT_ROWS];
		logic       last;
	} column_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	port_elem_t in_rows [PORT_ROWS];
	logic       in_last;
	logic       out_valid;
	logic       out_ready = 1'b0;
	port_elem_t out_row0, out_row1, out_row2, out_row3;
	port_elem_t out_row4, out_row5, out_row6, out_row7;
	logic       out_last;

	// idling percentages for the current phase
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// columns of the matrix being loaded, and sorted columns awaiting output
	column_t matrix_q [$];
	column_t sorted_q [$];

	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	column_sort_three_key #(
		.COLS(COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_row0(in_rows[0]),
		.in_row1(in_rows[1]),
		.in_row2(in_rows[2]),
		.in_row3(in_rows[3]),
		.in_row4(in_rows[4]),
		.in_row5(in_rows[5]),
		.in_row6(in_rows[6]),
		.in_row7(in_rows[7]),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_row0(out_row0),
		.out_row1(out_row1),
		.out_row2(out_row2),
		.out_row3(out_row3),
		.out_row4(out_row4),
		.out_row5(out_row5),
		.out_row6(out_row6),
		.out_row7(out_row7),
		.out_last(out_last)
	);

	// clock
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// true when column a has to sit behind column b
	function automatic bit goes_behind(column_t a, column_t b);
		if (a.rows[0] != b.rows[0]) begin
			return a.rows[0] > b.rows[0];
		end
		if (a.rows[1] != b.rows[1]) begin
			return a.rows[1] < b.rows[1];
		end
		return a.rows[2] > b.rows[2];
	endfunction

	// store an accepted column; on a closing column, sort and queue the whole matrix
	function automatic void store_column(column_t c);
		column_t tmp;
		int j;
		matrix_q.push_back(c);
		if (!c.last && matrix_q.size() < COLS) begin
			return;
		end
		// insertion sort keeps full ties in arrival order
		for (int i = 1; i < matrix_q.size(); i++) begin
			for (j = i; j > 0 && goes_behind(matrix_q[j-1], matrix_q[j]); j--) begin
				tmp = matrix_q[j-1];
				matrix_q[j-1] = matrix_q[j];
				matrix_q[j] = tmp;
			end
		end
		foreach (matrix_q[k]) begin
			tmp = matrix_q[k];
			tmp.last = (k == matrix_q.size() - 1);
			sorted_q.push_back(tmp);
		end
		matrix_q.delete();
	endfunction

	// key values biased towards extremes and near-zero so that ties are common
	function automatic port_elem_t pick_key();
		case ($urandom_range(0, 4))
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7fff;
			end
			2, 3: begin
				return port_elem_t'($urandom_range(0, 2)) - 16'sd1;
			end
			default: begin
				return port_elem_t'($urandom);
			end
		endcase
	endfunction

	function automatic column_t random_column(logic last);
		column_t c;
		for (int r = 0; r < PORT_ROWS; r++) begin
			c.rows[r] = (r < 3) ? pick_key() : port_elem_t'($urandom);
		end
		c.last = last;
		return c;
	endfunction

	// keys as given, payload rows 3, 4 and 7 derived from a tag so that moved columns are visible
	function automatic column_t make_column(port_elem_t k0, port_elem_t k1, port_elem_t k2,
			port_elem_t tag, logic last);
		column_t c;
		c.rows = '{k0, k1, k2, tag, ~tag, 16'sh8000, 16'sh7fff, tag ^ 16'sh5a5a};
		c.last = last;
		return c;
	endfunction

	// one column transfer on the input channel, then update the prediction
	task automatic send_column(input column_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_last <= c.last;
		for (int r = 0; r < PORT_ROWS; r++) begin
			in_rows[r] <= c.rows[r];
		end
		do @(posedge clk); while (!in_ready);
		store_column(c);
	endtask

	// lone column flagged last comes straight back with out_last set
	task automatic test_single_column();
		send_column(make_column(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1));
	endtask

	// two columns in reverse order swap
	task automatic test_two_columns();
		send_column(make_column(16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0001, 1'b0));
		send_column(make_column(16'sh8000, 16'sh0000, 16'sh0000, 16'sh0002, 1'b1));
	endtask

	// each key decides in turn, full ties hold arrival order
	task automatic test_key_order();
		send_column(make_column(16'sh0000, 16'sh0005, 16'sh0001, 16'sh0011, 1'b0));
		send_column(make_column(16'sh0000, 16'sh0005, 16'sh0001, 16'sh0022, 1'b0));
		send_column(make_column(16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0033, 1'b0));
		send_column(make_column(16'sh0000, 16'sh0005, 16'sh8000, 16'sh0044, 1'b0));
		send_column(make_column(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0055, 1'b0));
		send_column(make_column(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0066, 1'b1));
	endtask

	// a full store with no last flag closes the matrix by itself
	task automatic test_full_store();
		for (int i = 0; i < COLS; i++) begin
			send_column(make_column(port_elem_t'(COLS - i), 16'sh0000, 16'sh0000,
				port_elem_t'(i), 1'b0));
		end
	endtask

	// random matrices of random size under one idling setting
	task automatic test_random_matrices(input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned sent;
		int unsigned n;
		logic flag_end;
		sent = 0;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (sent < PHASE_ITEMS) begin
			n = ($urandom_range(0, 5) == 0) ? COLS : $urandom_range(1, COLS);
			flag_end = (n < COLS) ? 1'b1 : 1'($urandom_range(0, 1));
			for (int i = 0; i < n; i++) begin
				send_column(random_column((i == n - 1) && flag_end));
			end
			sent += n;
		end
	endtask

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		column_t want;
		port_elem_t got [PORT_ROWS];
		if (arst_n && out_valid && out_ready) begin
			got = '{out_row0, out_row1, out_row2, out_row3,
				out_row4, out_row5, out_row6, out_row7};
			if (sorted_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result transfer, row0 %0d", out_row0));
			end else begin
				want = sorted_q.pop_front();
				for (int r = 0; r < PORT_ROWS; r++) begin
					if (got[r] !== want.rows[r]) begin
						report_mismatch($sformatf("row%0d got %0d expected %0d",
							r, got[r], want.rows[r]));
					end
				end
				if (out_last !== want.last) begin
					report_mismatch($sformatf("out_last got %b expected %b", out_last, want.last));
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("column_sort_three_key verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_last = 1'b0;
		for (int r = 0; r < PORT_ROWS; r++) begin
			in_rows[r] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_column();
		test_two_columns();
		test_key_order();
		test_full_store();
		test_random_matrices(0, 0);
		test_random_matrices(85, 0);
		test_random_matrices(0, 85);
		test_random_matrices(26, 26);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sorted_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("column_sort_three_key verification clean");
		end else begin
			$display("column_sort_three_key verification failed");
		end
		$finish;
	end

endmodule
